// ===== rtl/prnfa_pkg.sv =====
// Shared codes and token decode for the postfix regex to NFA builder.
`default_nettype none
package prnfa_pkg;

  localparam logic [7:0] TOK_END  = 8'h00;
  localparam logic [7:0] TOK_CAT  = 8'h2E;
  localparam logic [7:0] TOK_ALT  = 8'h7C;
  localparam logic [7:0] TOK_STAR = 8'h2A;
  localparam logic [7:0] TOK_OPT  = 8'h3F;
  localparam logic [7:0] TOK_PLUS = 8'h2B;

  localparam logic [2:0] KIND_NODE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_UNDER = 3'd2;
  localparam logic [2:0] KIND_NODES = 3'd3;
  localparam logic [2:0] KIND_OVER  = 3'd4;

  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_SYM  = 2'd1;
  localparam logic [1:0] EDGE_EPS  = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_POP1  = 6'b000010,
    ST_POP2  = 6'b000100,
    ST_NODE1 = 6'b001000,
    ST_NODE2 = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  function automatic logic [1:0] tok_need_pop(input logic [7:0] tok);
    logic [1:0] n;
    case (tok)
      TOK_CAT, TOK_ALT:                     n = 2'd2;
      TOK_END, TOK_STAR, TOK_OPT, TOK_PLUS: n = 2'd1;
      default:                              n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] tok_need_nodes(input logic [7:0] tok);
    logic [1:0] n;
    case (tok)
      TOK_END, TOK_CAT: n = 2'd0;
      TOK_PLUS:         n = 2'd1;
      default:          n = 2'd2;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] tok_last_idx(input logic [7:0] tok);
    logic [1:0] n;
    case (tok)
      TOK_END, TOK_CAT:  n = 2'd0;
      TOK_STAR, TOK_OPT: n = 2'd2;
      TOK_ALT:           n = 2'd3;
      default:           n = 2'd1;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/postfix_regex_to_nfa_builder.sv =====
// Top level: Thompson NFA builder fed one postfix regex byte per item.
//
// Takes one postfix regex byte per item and reports every NFA node record it
// writes, one result per cycle while the result side does not stall. Node records
// live in a NODE_COUNT-entry memory and fragments in a STACK_DEPTH-entry memory,
// each with one registered read port. An item passes through an accept state,
// one state per stack pop, one per node read of a popped fragment's accept node
// and one emit step per result; an error skips the pops and gives one result.
// The next byte waits until the last result loads; the result side can stall it.
// Neither memory needs clearing after reset; the block takes items at once.
`default_nettype none
module postfix_regex_to_nfa_builder #(
  parameter int NODE_COUNT  = 256,
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       token_valid,
  output logic       token_ready,
  input  logic [7:0] token,
  output logic       record_valid,
  input  logic       record_ready,
  output logic [2:0] record_kind,
  output logic [7:0] node_index,
  output logic [1:0] edge_kind,
  output logic [7:0] edge_symbol,
  output logic [7:0] first_next,
  output logic [7:0] second_next,
  output logic       accepting,
  output logic       last_of_run
);
  import prnfa_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [1:0]    kind;
    logic [7:0]    sym;
    logic [NW-1:0] n1;
    logic [NW-1:0] n2;
    logic          acc;
  } node_t;

  typedef struct packed {
    logic [NW-1:0] start;
    logic [NW-1:0] acc_node;
  } frag_t;

  node_t node_mem [NODE_COUNT];
  frag_t stack_mem [STACK_DEPTH];

  state_t        state;
  logic [7:0]    tok;
  logic [2:0]    fault;
  logic [1:0]    emit_idx;
  frag_t         frag_a;
  frag_t         frag_b;
  logic [NW-1:0] n2_a;
  logic [NW-1:0] n2_b;
  logic [CW-1:0] next_free;
  logic [FW-1:0] fill;
  frag_t         stack_q;
  node_t         node_q;

  logic          stack_rd;
  logic [SW-1:0] stack_rd_addr;
  logic          stack_we;
  logic [SW-1:0] stack_wr_addr;
  frag_t         stack_wd;
  logic          node_rd;
  logic [NW-1:0] node_rd_addr;
  logic          node_we;

  logic [1:0]    in_pop;
  logic [1:0]    in_nodes;
  logic [CW:0]   nodes_sum;
  logic [2:0]    in_fault;
  logic [1:0]    tok_pop;
  logic [FW-1:0] fill_m1;
  logic [FW-1:0] fill_m2;
  logic [FW-1:0] push_pos;
  logic [NW-1:0] ns;
  logic [NW-1:0] na;
  node_t         res_rec;
  logic [NW-1:0] res_idx;
  logic [2:0]    res_kind;
  logic          res_last;
  logic          load;

  assign token_ready = (state == ST_IDLE);
  assign load        = (state == ST_EMIT) && (!record_valid || record_ready);

  assign in_pop    = tok_need_pop(token);
  assign in_nodes  = tok_need_nodes(token);
  assign nodes_sum = {1'b0, next_free} + (CW + 1)'(in_nodes);
  assign tok_pop   = tok_need_pop(tok);
  assign fill_m1   = fill - FW'(1);
  assign fill_m2   = fill - FW'(2);
  assign push_pos  = fill - FW'(tok_pop);
  assign ns        = next_free[NW-1:0];
  assign na        = ns + NW'(1);

  always_comb begin
    if (fill < FW'(in_pop)) begin
      in_fault = KIND_UNDER;
    end else if (nodes_sum > (CW + 1)'(NODE_COUNT)) begin
      in_fault = KIND_NODES;
    end else if (in_pop == 2'd0 && fill >= FW'(STACK_DEPTH)) begin
      in_fault = KIND_OVER;
    end else begin
      in_fault = KIND_NODE;
    end
  end

  always_comb begin
    stack_rd      = 1'b0;
    stack_rd_addr = fill_m1[SW-1:0];
    node_rd       = 1'b0;
    node_rd_addr  = stack_q.acc_node;
    case (state)
      ST_IDLE: begin
        stack_rd = token_valid && (fill != '0);
      end
      ST_POP1: begin
        if (tok_pop == 2'd2) begin
          stack_rd      = 1'b1;
          stack_rd_addr = fill_m2[SW-1:0];
        end else begin
          node_rd = (tok != TOK_END);
        end
      end
      ST_POP2: begin
        node_rd = 1'b1;
      end
      ST_NODE1: begin
        node_rd      = (tok == TOK_ALT);
        node_rd_addr = frag_b.acc_node;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_rec  = '0;
    res_idx  = '0;
    res_kind = fault;
    res_last = 1'b1;
    if (fault == KIND_NODE) begin
      res_last = (emit_idx == tok_last_idx(tok));
      case (tok)
        TOK_END: begin
          res_kind = KIND_START;
          res_idx  = frag_b.start;
        end
        TOK_CAT: begin
          res_idx = frag_a.acc_node;
          res_rec = '{EDGE_EPS, 8'd0, frag_b.start, n2_a, 1'b0};
        end
        TOK_ALT: begin
          case (emit_idx)
            2'd0: begin
              res_idx = ns;
              res_rec = '{EDGE_EPS, 8'd0, frag_a.start, frag_b.start, 1'b0};
            end
            2'd1: begin
              res_idx = na;
              res_rec = '{EDGE_NONE, 8'd0, '0, '0, 1'b1};
            end
            2'd2: begin
              res_idx = frag_a.acc_node;
              res_rec = '{EDGE_EPS, 8'd0, na, n2_a, 1'b0};
            end
            default: begin
              res_idx = frag_b.acc_node;
              res_rec = '{EDGE_EPS, 8'd0, na, n2_b, 1'b0};
            end
          endcase
        end
        TOK_STAR, TOK_OPT: begin
          case (emit_idx)
            2'd0: begin
              res_idx = ns;
              res_rec = '{EDGE_EPS, 8'd0, frag_a.start, na, 1'b0};
            end
            2'd1: begin
              res_idx = na;
              res_rec = '{EDGE_NONE, 8'd0, '0, '0, 1'b1};
            end
            default: begin
              res_idx = frag_a.acc_node;
              if (tok == TOK_STAR) begin
                res_rec = '{EDGE_EPS, 8'd0, frag_a.start, na, 1'b0};
              end else begin
                res_rec = '{EDGE_EPS, 8'd0, na, n2_a, 1'b0};
              end
            end
          endcase
        end
        TOK_PLUS: begin
          if (emit_idx == 2'd0) begin
            res_idx = ns;
            res_rec = '{EDGE_EPS, 8'd0, '0, frag_a.start, 1'b1};
          end else begin
            res_idx = frag_a.acc_node;
            res_rec = '{EDGE_EPS, 8'd0, ns, n2_a, 1'b0};
          end
        end
        default: begin
          if (emit_idx == 2'd0) begin
            res_idx = ns;
            res_rec = '{EDGE_SYM, tok, na, '0, 1'b0};
          end else begin
            res_idx = na;
            res_rec = '{EDGE_NONE, 8'd0, '0, '0, 1'b1};
          end
        end
      endcase
    end
  end

  assign node_we  = load && (fault == KIND_NODE) && (tok != TOK_END);
  assign stack_we = load && res_last && (fault == KIND_NODE) && (tok != TOK_END);
  assign stack_wr_addr = push_pos[SW-1:0];

  always_comb begin
    case (tok)
      TOK_CAT:  stack_wd = '{frag_a.start, frag_b.acc_node};
      TOK_PLUS: stack_wd = '{frag_a.start, ns};
      default:  stack_wd = '{ns, na};
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[res_idx] <= res_rec;
    end
    if (node_rd) begin
      node_q <= node_mem[node_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_wr_addr] <= stack_wd;
    end
    if (stack_rd) begin
      stack_q <= stack_mem[stack_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (token_valid) begin
          tok      <= token;
          fault    <= in_fault;
          emit_idx <= 2'd0;
        end
      end
      ST_POP1: begin
        frag_a <= stack_q;
        frag_b <= stack_q;
      end
      ST_POP2: begin
        frag_a <= stack_q;
      end
      ST_NODE1: begin
        n2_a <= node_q.n2;
      end
      ST_NODE2: begin
        n2_b <= node_q.n2;
      end
      default: begin
        if (load) begin
          emit_idx <= emit_idx + 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      record_kind <= res_kind;
      node_index  <= 8'(res_idx);
      edge_kind   <= res_rec.kind;
      edge_symbol <= res_rec.sym;
      first_next  <= 8'(res_rec.n1);
      second_next <= 8'(res_rec.n2);
      accepting   <= res_rec.acc;
      last_of_run <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      record_valid <= 1'b0;
      next_free    <= CW'(1);
      fill         <= '0;
    end else begin
      if (load) begin
        record_valid <= 1'b1;
      end else if (record_ready) begin
        record_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (token_valid) begin
            if (in_fault != KIND_NODE || in_pop == 2'd0) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_POP1;
            end
          end
        end
        ST_POP1: begin
          if (tok == TOK_END) begin
            state <= ST_EMIT;
          end else if (tok_pop == 2'd2) begin
            state <= ST_POP2;
          end else begin
            state <= ST_NODE1;
          end
        end
        ST_POP2: begin
          state <= ST_NODE1;
        end
        ST_NODE1: begin
          state <= (tok == TOK_ALT) ? ST_NODE2 : ST_EMIT;
        end
        ST_NODE2: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load && res_last) begin
            state <= ST_IDLE;
            if (fault == KIND_NODE) begin
              if (tok == TOK_END) begin
                next_free <= CW'(1);
                fill      <= '0;
              end else begin
                next_free <= next_free + CW'(tok_need_nodes(tok));
                fill      <= push_pos + FW'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(STACK_DEPTH))
    else $error("fragment stack fill beyond depth");

  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    next_free != '0 && {1'b0, next_free} <= (CW + 1)'(NODE_COUNT))
    else $error("node counter out of range");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_ready |=> !token_ready)
    else $error("second item taken while one is in flight");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    load && res_last |=> token_ready)
    else $error("final result did not free the input");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    record_valid && (record_kind == KIND_UNDER || record_kind == KIND_NODES ||
    record_kind == KIND_OVER) |-> node_index == 8'd0 && first_next == 8'd0 &&
    second_next == 8'd0 && last_of_run)
    else $error("error result carries node data");

endmodule
`default_nettype wire

// ===== tb/tb_postfix_regex_to_nfa_builder.sv =====
// Self-checking testbench for the postfix regex to Thompson NFA builder.
module tb_postfix_regex_to_nfa_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import prnfa_pkg::*;

  localparam int NODES      = 256;
  localparam int STACK      = 64;
  localparam int RAND_ITEMS = 6;
  localparam int QUIET_TAIL = 30;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic [1:0] ek;
    logic [7:0] sym;
    logic [7:0] nx1;
    logic [7:0] nx2;
    logic       acc;
  } nfa_node_t;

  typedef struct packed {
    logic [7:0] start_n;
    logic [7:0] accept_n;
  } frag_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] idx;
    logic [1:0] ek;
    logic [7:0] sym;
    logic [7:0] nx1;
    logic [7:0] nx2;
    logic       acc;
    logic       last;
  } record_t;

  typedef struct {
    bit         drain;
    logic [7:0] tok;
  } pending_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       token_valid = 1'b0;
  logic       token_ready;
  logic [7:0] token = 8'h00;
  logic       record_valid;
  logic       record_ready = 1'b0;
  logic [2:0] record_kind;
  logic [7:0] node_index;
  logic [1:0] edge_kind;
  logic [7:0] edge_symbol;
  logic [7:0] first_next;
  logic [7:0] second_next;
  logic       accepting;
  logic       last_of_run;

  nfa_node_t node_tab [NODES];
  frag_t     frag_stk [STACK];
  int        free_node = 1;
  int        frag_fill = 0;

  record_t   want_q[$];
  pending_t  pending_q[$];
  bit        quiet = 1'b0;
  int        src_gap = 0;
  int        sink_stall = 0;
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        kind_cnt [8];

  postfix_regex_to_nfa_builder #(
    .NODE_COUNT (NODES),
    .STACK_DEPTH(STACK)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token),
    .record_valid(record_valid),
    .record_ready(record_ready),
    .record_kind (record_kind),
    .node_index  (node_index),
    .edge_kind   (edge_kind),
    .edge_symbol (edge_symbol),
    .first_next  (first_next),
    .second_next (second_next),
    .accepting   (accepting),
    .last_of_run (last_of_run)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("postfix_regex_to_nfa_builder test failed");
    $finish;
  end

  // ---------------- NFA prediction ----------------

  task automatic push_status(input logic [2:0] kind, input logic [7:0] idx);
    record_t r;
    r = '0;
    r.kind = kind;
    r.idx = idx;
    r.last = 1'b1;
    want_q.push_back(r);
  endtask

  task automatic push_node(input int idx, input bit last);
    record_t r;
    r.kind = KIND_NODE;
    r.idx = idx[7:0];
    r.ek = node_tab[idx].ek;
    r.sym = node_tab[idx].sym;
    r.nx1 = node_tab[idx].nx1;
    r.nx2 = node_tab[idx].nx2;
    r.acc = node_tab[idx].acc;
    r.last = last;
    want_q.push_back(r);
  endtask

  function automatic int alloc_node(input logic [1:0] ek, input logic [7:0] sym,
                                    input int nx1, input int nx2, input bit acc);
    int idx;
    idx = free_node;
    free_node++;
    node_tab[idx] = '{ek: ek, sym: sym, nx1: nx1[7:0], nx2: nx2[7:0], acc: acc};
    return idx;
  endfunction

  function automatic void link_eps(input int node, input int target);
    node_tab[node].acc = 1'b0;
    node_tab[node].ek = EDGE_EPS;
    node_tab[node].sym = 8'h00;
    node_tab[node].nx1 = target[7:0];
  endfunction

  function automatic frag_t pop_frag();
    frag_fill--;
    return frag_stk[frag_fill];
  endfunction

  function automatic void push_frag(input int s, input int a);
    frag_stk[frag_fill] = '{start_n: s[7:0], accept_n: a[7:0]};
    frag_fill++;
  endfunction

  task automatic predict_records(input logic [7:0] tok);
    int pops;
    int need;
    int ns;
    int na;
    frag_t f1;
    frag_t f2;
    case (tok)
      TOK_END:  begin pops = 1; need = 0; end
      TOK_CAT:  begin pops = 2; need = 0; end
      TOK_ALT:  begin pops = 2; need = 2; end
      TOK_STAR: begin pops = 1; need = 2; end
      TOK_OPT:  begin pops = 1; need = 2; end
      TOK_PLUS: begin pops = 1; need = 1; end
      default:  begin pops = 0; need = 2; end
    endcase
    if (frag_fill < pops) begin
      push_status(KIND_UNDER, 8'h00);
    end else if (free_node + need > NODES) begin
      push_status(KIND_NODES, 8'h00);
    end else if (pops == 0 && frag_fill >= STACK) begin
      push_status(KIND_OVER, 8'h00);
    end else begin
      case (tok)
        TOK_END: begin
          f1 = pop_frag();
          push_status(KIND_START, f1.start_n);
          free_node = 1;
          frag_fill = 0;
        end
        TOK_CAT: begin
          f2 = pop_frag();
          f1 = pop_frag();
          link_eps(f1.accept_n, f2.start_n);
          push_frag(f1.start_n, f2.accept_n);
          push_node(f1.accept_n, 1'b1);
        end
        TOK_ALT: begin
          f2 = pop_frag();
          f1 = pop_frag();
          ns = alloc_node(EDGE_EPS, 8'h00, f1.start_n, f2.start_n, 1'b0);
          na = alloc_node(EDGE_NONE, 8'h00, 0, 0, 1'b1);
          link_eps(f1.accept_n, na);
          link_eps(f2.accept_n, na);
          push_frag(ns, na);
          push_node(ns, 1'b0);
          push_node(na, 1'b0);
          push_node(f1.accept_n, 1'b0);
          push_node(f2.accept_n, 1'b1);
        end
        TOK_STAR: begin
          f1 = pop_frag();
          ns = alloc_node(EDGE_EPS, 8'h00, 0, 0, 1'b0);
          na = alloc_node(EDGE_NONE, 8'h00, 0, 0, 1'b1);
          node_tab[ns].nx1 = f1.start_n;
          node_tab[ns].nx2 = na[7:0];
          link_eps(f1.accept_n, f1.start_n);
          node_tab[f1.accept_n].nx2 = na[7:0];
          push_frag(ns, na);
          push_node(ns, 1'b0);
          push_node(na, 1'b0);
          push_node(f1.accept_n, 1'b1);
        end
        TOK_OPT: begin
          f1 = pop_frag();
          ns = alloc_node(EDGE_EPS, 8'h00, 0, 0, 1'b0);
          na = alloc_node(EDGE_NONE, 8'h00, 0, 0, 1'b1);
          node_tab[ns].nx1 = f1.start_n;
          node_tab[ns].nx2 = na[7:0];
          link_eps(f1.accept_n, na);
          push_frag(ns, na);
          push_node(ns, 1'b0);
          push_node(na, 1'b0);
          push_node(f1.accept_n, 1'b1);
        end
        TOK_PLUS: begin
          f1 = pop_frag();
          na = alloc_node(EDGE_EPS, 8'h00, 0, f1.start_n, 1'b1);
          link_eps(f1.accept_n, na);
          push_frag(f1.start_n, na);
          push_node(na, 1'b0);
          push_node(f1.accept_n, 1'b1);
        end
        default: begin
          ns = alloc_node(EDGE_SYM, tok, 0, 0, 1'b0);
          na = alloc_node(EDGE_NONE, 8'h00, 0, 0, 1'b1);
          node_tab[ns].nx1 = na[7:0];
          push_frag(ns, na);
          push_node(ns, 1'b0);
          push_node(na, 1'b1);
        end
      endcase
    end
  endtask

  // ---------------- stimulus generation ----------------

  task automatic add_tok(input logic [7:0] tok);
    pending_q.push_back('{drain: 1'b0, tok: tok});
  endtask

  task automatic add_drain();
    pending_q.push_back('{drain: 1'b1, tok: 8'h00});
  endtask

  function automatic logic [7:0] rand_literal();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == TOK_CAT || b == TOK_ALT || b == TOK_STAR ||
               b == TOK_OPT || b == TOK_PLUS);
    return b;
  endfunction

  function automatic logic [7:0] rand_operator();
    logic [7:0] ops [6];
    ops = '{TOK_END, TOK_CAT, TOK_ALT, TOK_STAR, TOK_OPT, TOK_PLUS};
    return ops[$urandom_range(0, 5)];
  endfunction

  // well-formed postfix expression followed by the end byte
  task automatic gen_expr(input int n, inout int count);
    int depth;
    int r;
    depth = 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (depth == 0 || (r < 4 && depth < 8)) begin
        add_tok(rand_literal());
        depth++;
      end else if (r < 7 || depth < 2) begin
        case ($urandom_range(0, 2))
          0:       add_tok(TOK_STAR);
          1:       add_tok(TOK_OPT);
          default: add_tok(TOK_PLUS);
        endcase
      end else begin
        add_tok($urandom_range(0, 1) ? TOK_CAT : TOK_ALT);
        depth--;
      end
      count++;
    end
    while (depth > 1) begin
      add_tok($urandom_range(0, 1) ? TOK_CAT : TOK_ALT);
      depth--;
      count++;
    end
    add_tok(TOK_END);
    count++;
  endtask

  // broken or random sequences, always closed by the end byte
  task automatic gen_noise(input int n, inout int count);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0:       add_tok(rand_operator());
        1:       add_tok(rand_literal());
        default: add_tok(8'($urandom_range(0, 255)));
      endcase
      count++;
    end
    add_tok(TOK_END);
    count++;
  endtask

  task automatic build_stimulus();
    int count;
    // underflow of every operation from an empty stack
    add_tok(TOK_END);
    add_tok(TOK_STAR);
    add_tok(TOK_OPT);
    add_tok(TOK_PLUS);
    add_tok(TOK_CAT);
    add_tok(TOK_ALT);
    // each operation on extreme literals
    add_tok(8'hFF);
    add_tok(TOK_CAT);
    add_tok(TOK_ALT);
    add_tok(8'h01);
    add_tok(TOK_ALT);
    add_tok(TOK_STAR);
    add_tok(8'h80);
    add_tok(TOK_CAT);
    add_tok(TOK_OPT);
    add_tok(8'h7F);
    add_tok(TOK_PLUS);
    add_tok(TOK_CAT);
    add_tok(TOK_END);
    // leftover fragments at the end byte
    add_tok(8'h61);
    add_tok(8'h62);
    add_tok(8'h63);
    add_tok(TOK_END);
    // repeated one-or-more keeps the loop link, then concatenation
    add_tok(8'h78);
    add_tok(TOK_PLUS);
    add_tok(TOK_PLUS);
    add_tok(8'h79);
    add_tok(TOK_CAT);
    add_tok(TOK_END);
    add_drain();

    // fill the stack, then overflow it
    for (int i = 0; i < STACK; i++) add_tok(rand_literal());
    add_tok(rand_literal());
    add_tok(TOK_STAR);
    add_tok(TOK_ALT);
    add_tok(rand_literal());
    add_tok(TOK_END);
    add_drain();

    count = 0;
    while (count < RAND_ITEMS) begin
      if ($urandom_range(0, 4) == 0) gen_noise($urandom_range(1, 8), count);
      else gen_expr($urandom_range(1, 16), count);
      if ($urandom_range(0, 3) == 0) add_drain();
    end
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    logic     nv;
    pending_t p;
    if (rst) begin
      token_valid <= 1'b0;
      token <= 8'h00;
      src_gap = 0;
    end else begin
      if (token_valid && token_ready) begin
        predict_records(token);
        items_sent++;
      end
      quiet = (pending_q.size() <= QUIET_TAIL);
      if (!token_valid || token_ready) begin
        nv = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].drain) begin
            if (want_q.size() == 0 && !token_valid) void'(pending_q.pop_front());
          end else if (!quiet && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 2);
          end else begin
            p = pending_q.pop_front();
            token <= p.tok;
            nv = 1'b1;
          end
        end
        token_valid <= nv;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    record_t got;
    record_t want;
    logic    rr;
    if (rst) begin
      record_ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (record_valid && record_ready) begin
        got = '{kind: record_kind, idx: node_index, ek: edge_kind, sym: edge_symbol,
                nx1: first_next, nx2: second_next, acc: accepting, last: last_of_run};
        kind_cnt[got.kind]++;
        if (want_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("%0t: unexpected record kind=%0d idx=%0d", $realtime, got.kind,
                     got.idx);
        end else begin
          want = want_q.pop_front();
          if (got.kind !== want.kind || got.idx !== want.idx || got.ek !== want.ek ||
              got.sym !== want.sym || got.nx1 !== want.nx1 || got.nx2 !== want.nx2 ||
              got.acc !== want.acc || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
              $display({"%0t: mismatch exp kind=%0d idx=%0d edge=%0d sym=%h n1=%0d ",
                        "n2=%0d acc=%b last=%b got kind=%0d idx=%0d edge=%0d sym=%h ",
                        "n1=%0d n2=%0d acc=%b last=%b"}, $realtime,
                       want.kind, want.idx, want.ek, want.sym, want.nx1, want.nx2,
                       want.acc, want.last, got.kind, got.idx, got.ek, got.sym,
                       got.nx1, got.nx2, got.acc, got.last);
          end
        end
      end
      rr = 1'b1;
      if (sink_stall > 0) begin
        sink_stall--;
        rr = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        sink_stall = $urandom_range(0, 2);
        rr = 1'b0;
      end
      record_ready <= rr;
    end
  end

  // ---------------- sequence and end of run ----------------

  initial begin
    for (int k = 0; k < 8; k++) kind_cnt[k] = 0;
    build_stimulus();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0 || token_valid || want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (want_q.size() != 0) begin
      mismatch_count += want_q.size();
      $display("%0d expected records never arrived", want_q.size());
    end
    $display("Ran %0d postfix bytes: %0d node records, %0d start reports,", items_sent,
             kind_cnt[KIND_NODE], kind_cnt[KIND_START]);
    $display("  %0d underflow, %0d out-of-nodes, %0d overflow results; %0d failures",
             kind_cnt[KIND_UNDER], kind_cnt[KIND_NODES], kind_cnt[KIND_OVER],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("postfix_regex_to_nfa_builder test passed");
    end else begin
      $display("postfix_regex_to_nfa_builder test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/prnfa_pkg.sv
rtl/postfix_regex_to_nfa_builder.sv
tb/tb_postfix_regex_to_nfa_builder.sv
